/* rtl/twb_pkg.sv */
// twb_pkg: shared constants and types of the trie word-break block
// no dependencies; compiled before every other file of the block

package twb_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int ALPHABET_DEF   = 26;
  localparam int TEXT_MAX_DEF   = 4096;

  localparam int LETTER_W = 5;
  localparam int PREFIX_W = 13;
  localparam int ERROR_W  = 2;

  localparam logic FUNC_DICT = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  localparam logic [ERROR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_TRIE = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_TEXT = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [PREFIX_W-1:0] prefix_length;
    logic [ERROR_W-1:0]  error;
  } twb_result_t;

endpackage

/* rtl/twb_in_if.sv */
// twb_in_if: request channel carrying one letter per request
// depends on twb_pkg for field widths

interface twb_in_if import twb_pkg::*;;
  logic                valid;
  logic                ready;
  logic                func;
  logic [LETTER_W-1:0] letter;
  logic                last;

  modport source (output valid, func, letter, last, input ready);
  modport sink   (input valid, func, letter, last, output ready);
endinterface

/* rtl/twb_out_if.sv */
// twb_out_if: result channel carrying the segmentation answer
// depends on twb_pkg for field widths

interface twb_out_if import twb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [PREFIX_W-1:0] prefix_length;
  logic [ERROR_W-1:0]  error;

  modport source (output valid, prefix_length, error, input ready);
  modport sink   (input valid, prefix_length, error, output ready);
endinterface

/* rtl/twb_trie.sv */
// twb_trie: trie child table and terminal marks, insert sequencer, clear pass
// depends on twb_pkg

module twb_trie import twb_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ALPHABET   = ALPHABET_DEF,
  localparam int NW = $clog2(NODE_COUNT),
  localparam int AW = $clog2(ALPHABET)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ins_valid_i,
  input  logic [LETTER_W-1:0] ins_letter_i,
  input  logic                ins_last_i,
  input  logic                lk_child_en_i,
  input  logic [NW-1:0]       lk_node_i,
  input  logic [AW-1:0]       lk_letter_i,
  input  logic                lk_term_en_i,
  input  logic [NW-1:0]       lk_term_node_i,
  output logic [NW-1:0]       child_o,
  output logic                term_o,
  output logic                busy_o,
  output logic                overflow_o
);

  localparam int CW    = NW + AW;
  localparam int DEPTH = NODE_COUNT * (2 ** AW);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [NW-1:0] child_mem [DEPTH];
  logic          term_mem  [NODE_COUNT];

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [NW:0]   count_q, count_d;
  logic [NW-1:0] cursor_q, cursor_d;
  logic          ovf_q, ovf_d;
  logic          last_q, last_d;
  logic [CW-1:0] slot_q, slot_d;
  logic [NW-1:0] child_rd_q;
  logic          term_rd_q;

  logic          cw_en, tw_en, tw_data, rd_en, in_range, ovf_n;
  logic [CW-1:0] cw_addr, rd_addr, ins_addr;
  logic [NW-1:0] cw_data, tw_addr, nxt, cur_n;
  logic [NW:0]   count_inc;

  assign in_range  = int'(ins_letter_i) < ALPHABET;
  assign ins_addr  = {cursor_q, AW'(ins_letter_i)};
  assign count_inc = (NW+1)'(count_q + 1'b1);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    ovf_d    = ovf_q;
    last_d   = last_q;
    slot_d   = slot_q;
    cw_en    = 1'b0;
    cw_addr  = slot_q;
    cw_data  = '0;
    tw_en    = 1'b0;
    tw_addr  = cursor_q;
    tw_data  = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = {lk_node_i, lk_letter_i};
    nxt      = child_rd_q;
    ovf_n    = ovf_q;
    cur_n    = cursor_q;
    case (state_q)
      ST_CLEAR: begin
        cw_en   = 1'b1;
        cw_addr = clr_q;
        if (clr_q[AW-1:0] == '0) begin
          tw_en   = 1'b1;
          tw_addr = clr_q[CW-1:AW];
          tw_data = 1'b0;
        end
        if (clr_q == CW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (ins_valid_i) begin
          if (!ovf_q && in_range) begin
            rd_en   = 1'b1;
            rd_addr = ins_addr;
            slot_d  = ins_addr;
            last_d  = ins_last_i;
            state_d = ST_WAIT;
          end else if (ins_last_i) begin
            tw_en    = !ovf_q;
            cursor_d = '0;
          end
        end else begin
          rd_en = lk_child_en_i;
        end
      end
      ST_WAIT: begin
        // child missing: allocate the next node unless the store is full
        if (child_rd_q == '0) begin
          if (count_inc >= (NW+1)'(NODE_COUNT)) begin
            ovf_n = 1'b1;
          end else begin
            count_d = count_inc;
            nxt     = NW'(count_inc);
            cw_en   = 1'b1;
            cw_data = nxt;
          end
        end
        ovf_d = ovf_n;
        cur_n = ovf_n ? cursor_q : nxt;
        if (last_q) begin
          tw_en   = !ovf_n;
          tw_addr = cur_n;
          cur_n   = '0;
        end
        cursor_d = cur_n;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      count_q  <= '0;
      cursor_q <= '0;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
      slot_q   <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      ovf_q    <= ovf_d;
      last_q   <= last_d;
      slot_q   <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      child_mem[cw_addr] <= cw_data;
    end
    if (rd_en) begin
      child_rd_q <= child_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      term_mem[tw_addr] <= tw_data;
    end
    if (lk_term_en_i) begin
      term_rd_q <= term_mem[lk_term_node_i];
    end
  end

  assign child_o    = child_rd_q;
  assign term_o     = term_rd_q;
  assign busy_o     = state_q != ST_IDLE;
  assign overflow_o = ovf_q;

endmodule

/* rtl/twb_seg.sv */
// twb_seg: text buffer, reachable marks and the word-break walk sequencer
// depends on twb_pkg; drives the lookup port of twb_trie

module twb_seg import twb_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ALPHABET   = ALPHABET_DEF,
  parameter int TEXT_MAX   = TEXT_MAX_DEF,
  localparam int NW = $clog2(NODE_COUNT),
  localparam int AW = $clog2(ALPHABET)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                txt_valid_i,
  input  logic [LETTER_W-1:0] txt_letter_i,
  input  logic                txt_last_i,
  input  logic                trie_ovf_i,
  input  logic [NW-1:0]       child_i,
  input  logic                term_i,
  input  logic                out_free_i,
  output logic                lk_child_en_o,
  output logic [NW-1:0]       lk_node_o,
  output logic [AW-1:0]       lk_letter_o,
  output logic                lk_term_en_o,
  output logic [NW-1:0]       lk_term_node_o,
  output logic                busy_o,
  output twb_result_t         res_o
);

  localparam int LW  = $clog2(TEXT_MAX + 1);
  localparam int TAW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RI   = 4'd2;
  localparam logic [3:0] S_RC   = 4'd3;
  localparam logic [3:0] S_TX   = 4'd4;
  localparam logic [3:0] S_TC   = 4'd5;
  localparam logic [3:0] S_CH   = 4'd6;
  localparam logic [3:0] S_TM   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [LETTER_W-1:0] txt_mem   [TEXT_MAX];
  logic                reach_mem [TEXT_MAX + 1];

  logic [3:0]          state_q, state_d;
  logic [LW-1:0]       len_q, len_d, i_q, i_d, j_q, j_d, best_q, best_d;
  logic [NW-1:0]       u_q, u_d;
  logic                ovf_q, ovf_d;
  logic [LETTER_W-1:0] txt_rd_q;
  logic                reach_rd_q;

  logic                tw_en, rw_en, rw_data, rr_en, tr_en, advance;
  logic [LW-1:0]       rw_addr, j_inc;

  assign j_inc = LW'(j_q + 1'b1);

  always_comb begin
    state_d        = state_q;
    len_d          = len_q;
    i_d            = i_q;
    j_d            = j_q;
    best_d         = best_q;
    u_d            = u_q;
    ovf_d          = ovf_q;
    tw_en          = 1'b0;
    rw_en          = 1'b0;
    rw_addr        = i_q;
    rw_data        = 1'b0;
    rr_en          = 1'b0;
    tr_en          = 1'b0;
    advance        = 1'b0;
    lk_child_en_o  = 1'b0;
    lk_letter_o    = AW'(txt_rd_q);
    lk_term_en_o   = 1'b0;
    res_o.valid         = 1'b0;
    res_o.prefix_length = PREFIX_W'(best_q);
    res_o.error         = ovf_q ? ERR_TEXT : (trie_ovf_i ? ERR_TRIE : ERR_OK);
    case (state_q)
      S_CLR: begin
        rw_en   = 1'b1;
        rw_addr = i_q;
        if (i_q == LW'(TEXT_MAX)) begin
          i_d     = '0;
          state_d = S_IDLE;
        end else begin
          i_d = LW'(i_q + 1'b1);
        end
      end
      S_IDLE: begin
        if (txt_valid_i) begin
          if (len_q < LW'(TEXT_MAX)) begin
            tw_en = 1'b1;
            len_d = LW'(len_q + 1'b1);
          end else begin
            ovf_d = 1'b1;
          end
          if (txt_last_i) begin
            i_d     = '0;
            best_d  = '0;
            state_d = S_RI;
          end
        end
      end
      S_RI: begin
        rr_en   = 1'b1;
        state_d = S_RC;
      end
      S_RC: begin
        // read mark is consumed and cleared so the store is blank next query
        rw_en = 1'b1;
        if (reach_rd_q || i_q == '0) begin
          best_d = i_q;
          if (i_q < len_q) begin
            j_d     = i_q;
            u_d     = '0;
            state_d = S_TX;
          end else begin
            advance = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
      end
      S_TX: begin
        tr_en   = 1'b1;
        state_d = S_TC;
      end
      S_TC: begin
        if (int'(txt_rd_q) < ALPHABET) begin
          lk_child_en_o = 1'b1;
          state_d       = S_CH;
        end else begin
          advance = 1'b1;
        end
      end
      S_CH: begin
        if (child_i == '0) begin
          advance = 1'b1;
        end else begin
          u_d          = child_i;
          lk_term_en_o = 1'b1;
          state_d      = S_TM;
        end
      end
      S_TM: begin
        if (term_i) begin
          rw_en   = 1'b1;
          rw_addr = j_inc;
          rw_data = 1'b1;
        end
        j_d = j_inc;
        if (j_inc < len_q) begin
          state_d = S_TX;
        end else begin
          advance = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          len_d       = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (advance) begin
      if (i_q == len_q) begin
        state_d = S_DONE;
      end else begin
        i_d     = LW'(i_q + 1'b1);
        state_d = S_RI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      len_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      best_q  <= '0;
      u_q     <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      i_q     <= i_d;
      j_q     <= j_d;
      best_q  <= best_d;
      u_q     <= u_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      txt_mem[len_q[TAW-1:0]] <= txt_letter_i;
    end
    if (tr_en) begin
      txt_rd_q <= txt_mem[j_q[TAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rw_en) begin
      reach_mem[rw_addr] <= rw_data;
    end
    if (rr_en) begin
      reach_rd_q <= reach_mem[i_q];
    end
  end

  assign lk_node_o      = u_q;
  assign lk_term_node_o = child_i;
  assign busy_o         = state_q != S_IDLE;

endmodule

/* rtl/trie_word_break_longest_prefix.sv */
// trie_word_break_longest_prefix: top level, request/result handshake and output register
// depends on twb_pkg, twb_in_if, twb_out_if, twb_trie and twb_seg

// Letters arrive one per request. A dictionary letter (func 0) extends the
// trie: a letter that looks up a child reads the child table, then allocates
// and writes a node if the child is missing; any other is handled without
// the read. A text letter (func 1) goes into the text buffer. The text letter
// marked last starts the word-break walk, and no request is taken until its
// result has moved into the output register: the walk reads and clears the
// reachable mark of every position of the text, and from a reachable
// position takes trie steps (text read, child read, terminal read, mark
// write). It then hands the result to the output register, waiting while
// the previous result has not been taken yet.
// After reset the block takes no request while the child table and terminal
// marks are cleared; the TEXT_MAX+1 reachable marks are cleared at the same time.
// Error 2 reports a text longer than TEXT_MAX (extra letters dropped) and wins
// over error 1, which stays set for good once the trie node store is full.

module trie_word_break_longest_prefix import twb_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ALPHABET   = ALPHABET_DEF,
  parameter int TEXT_MAX   = TEXT_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  twb_in_if.sink      req_i,
  twb_out_if.source   res_o
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int AW = $clog2(ALPHABET);

  // shared lookup path between the walk sequencer and the trie store
  logic          lk_child_en, lk_term_en, child_term;
  logic [NW-1:0] lk_node, lk_term_node, child_node;
  logic [AW-1:0] lk_letter;
  logic          trie_busy, trie_ovf, seg_busy;
  logic          req_fire;
  twb_result_t   seg_res;

  // output register parts the result side from the walk
  logic                out_valid_q;
  logic [PREFIX_W-1:0] out_prefix_q;
  logic [ERROR_W-1:0]  out_error_q;

  assign req_i.ready = !trie_busy && !seg_busy;
  assign req_fire    = req_i.valid && req_i.ready;

  twb_trie #(
    .NODE_COUNT (NODE_COUNT),
    .ALPHABET   (ALPHABET)
  ) u_trie (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ins_valid_i    (req_fire && req_i.func == FUNC_DICT),
    .ins_letter_i   (req_i.letter),
    .ins_last_i     (req_i.last),
    .lk_child_en_i  (lk_child_en),
    .lk_node_i      (lk_node),
    .lk_letter_i    (lk_letter),
    .lk_term_en_i   (lk_term_en),
    .lk_term_node_i (lk_term_node),
    .child_o        (child_node),
    .term_o         (child_term),
    .busy_o         (trie_busy),
    .overflow_o     (trie_ovf)
  );

  twb_seg #(
    .NODE_COUNT (NODE_COUNT),
    .ALPHABET   (ALPHABET),
    .TEXT_MAX   (TEXT_MAX)
  ) u_seg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .txt_valid_i    (req_fire && req_i.func == FUNC_TEXT),
    .txt_letter_i   (req_i.letter),
    .txt_last_i     (req_i.last),
    .trie_ovf_i     (trie_ovf),
    .child_i        (child_node),
    .term_i         (child_term),
    .out_free_i     (!out_valid_q),
    .lk_child_en_o  (lk_child_en),
    .lk_node_o      (lk_node),
    .lk_letter_o    (lk_letter),
    .lk_term_en_o   (lk_term_en),
    .lk_term_node_o (lk_term_node),
    .busy_o         (seg_busy),
    .res_o          (seg_res)
  );

  // result is held until taken; the walk waits only if it is still full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seg_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_res.valid) begin
      out_prefix_q <= seg_res.prefix_length;
      out_error_q  <= seg_res.error;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.prefix_length = out_prefix_q;
  assign res_o.error         = out_error_q;

endmodule

/* bench/trie_word_break_longest_prefix_test.sv */
// trie_word_break_longest_prefix_test: self-checking bench for the trie word-break block
// depends on twb_pkg, twb_in_if, twb_out_if and the trie_word_break_longest_prefix rtl

module trie_word_break_longest_prefix_test;
  import twb_pkg::*;

  localparam int WATCHDOG_CYCLES = 400000;
  localparam int DRAIN_CYCLES    = 64;

  typedef struct packed {
    logic [PREFIX_W-1:0] prefix_length;
    logic [ERROR_W-1:0]  error;
  } answer_t;

  // keeps its own trie and text buffer, predicts one answer per closing text letter
  class twb_scoreboard;
    int unsigned         child_of [NODE_COUNT_DEF*ALPHABET_DEF];
    bit                  word_end [NODE_COUNT_DEF];
    int unsigned         nodes_made;
    int unsigned         cursor;
    logic [LETTER_W-1:0] text [TEXT_MAX_DEF];
    int unsigned         text_len;
    bit                  trie_full;
    bit                  text_dropped;
    answer_t             answers_q[$];
    int                  errors;

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    function int unsigned longest_prefix();
      bit          reach [TEXT_MAX_DEF+1];
      int unsigned best;
      int unsigned node;
      int unsigned nxt;
      best = 0;
      reach[0] = 1'b1;
      for (int unsigned i = 0; i <= text_len; i++) begin
        if (!reach[i]) continue;
        best = i;
        node = 0;
        for (int unsigned j = i; j < text_len; j++) begin
          if (text[j] >= ALPHABET_DEF) break;
          nxt = child_of[node*ALPHABET_DEF + text[j]];
          if (nxt == 0 || nxt >= NODE_COUNT_DEF) break;
          node = nxt;
          if (word_end[node]) reach[j+1] = 1'b1;
        end
      end
      return best;
    endfunction

    function void note(logic func, logic [LETTER_W-1:0] letter, logic last);
      int unsigned slot;
      int unsigned nxt;
      answer_t     ans;
      if (func == FUNC_DICT) begin
        if (!trie_full && letter < ALPHABET_DEF) begin
          slot = cursor*ALPHABET_DEF + letter;
          nxt  = child_of[slot];
          if (nxt == 0) begin
            if (nodes_made + 1 >= NODE_COUNT_DEF) trie_full = 1'b1;
            else begin
              nodes_made++;
              nxt = nodes_made;
              child_of[slot] = nxt;
            end
          end
          if (!trie_full) cursor = nxt;
        end
        if (last) begin
          if (!trie_full) word_end[cursor] = 1'b1;
          cursor = 0;
        end
      end else begin
        if (text_len < TEXT_MAX_DEF) begin
          text[text_len] = letter;
          text_len++;
        end else text_dropped = 1'b1;
        if (last) begin
          ans.prefix_length = PREFIX_W'(longest_prefix());
          ans.error = text_dropped ? ERR_TEXT : (trie_full ? ERR_TRIE : ERR_OK);
          answers_q.push_back(ans);
          text_len = 0;
          text_dropped = 1'b0;
        end
      end
    endfunction

    task check(answer_t got);
      answer_t want;
      if (answers_q.size() == 0) begin
        report($sformatf("unexpected result len %0d err %0d", got.prefix_length, got.error));
        return;
      end
      want = answers_q.pop_front();
      if (got.prefix_length !== want.prefix_length)
        report($sformatf("prefix_length %0d, want %0d", got.prefix_length, want.prefix_length));
      if (got.error !== want.error)
        report($sformatf("error %0d, want %0d", got.error, want.error));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;        // no idling on either side while set
  int   quiet_cycles;
  int   sent;
  twb_scoreboard sb;

  twb_in_if  req_if ();
  twb_out_if res_if ();

  trie_word_break_longest_prefix DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #2 clk_i = ~clk_i;

  // idle at random with a chance of roughly 37 in 100, unless in the calm stretch
  function automatic bit want_idle();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  // one request: random idle cycles first, then hold until ready
  task send(logic func, logic [LETTER_W-1:0] letter, logic last);
    while (want_idle()) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.func   <= func;
    req_if.letter <= letter;
    req_if.last   <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note(func, letter, last);
    sent++;
  endtask

  // a dictionary word of given length; letters mostly from a small set so texts match
  task send_word(int len, int span);
    for (int k = 0; k < len; k++)
      send(FUNC_DICT,
           LETTER_W'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(span)),
           k == len-1);
  endtask

  task send_text(int len, int span);
    for (int k = 0; k < len; k++)
      send(FUNC_TEXT,
           LETTER_W'(($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(span)),
           k == len-1);
  endtask

  // a long text of one letter, every position reachable when the letter is a word
  task send_run(logic [LETTER_W-1:0] letter, int len);
    for (int k = 0; k < len; k++) send(FUNC_TEXT, letter, k == len-1);
  endtask

  // result side: check on handshake, stall at random
  always @(posedge clk_i) begin
    answer_t got;
    if (res_if.valid && res_if.ready) begin
      got.prefix_length = res_if.prefix_length;
      got.error         = res_if.error;
      sb.check(got);
    end
    if (rst_ni) res_if.ready <= !want_idle();
  end

  // watchdog: cycles with neither a request nor a result taken
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    calm = 1'b0;
    quiet_cycles = 0;
    sent = 0;
    req_if.valid  = 1'b0;
    req_if.func   = FUNC_DICT;
    req_if.letter = '0;
    req_if.last   = 1'b0;
    res_if.ready  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: words a, ab, z; out-of-alphabet word end leaves root terminal (no effect)
    send(FUNC_DICT, 0, 1'b1);
    send(FUNC_DICT, 0, 1'b0);
    send(FUNC_DICT, 1, 1'b1);
    send(FUNC_DICT, 25, 1'b1);
    send(FUNC_DICT, 31, 1'b1);
    // text aab: the split a|ab reaches 3
    send(FUNC_TEXT, 0, 1'b0);
    send(FUNC_TEXT, 0, 1'b0);
    send(FUNC_TEXT, 1, 1'b1);
    // out-of-alphabet letter stops the walk
    send(FUNC_TEXT, 25, 1'b0);
    send(FUNC_TEXT, 30, 1'b0);
    send(FUNC_TEXT, 0, 1'b1);
    // single letter that starts no word
    send(FUNC_TEXT, 31, 1'b1);
    // dictionary letters mixed into a text
    send(FUNC_TEXT, 1, 1'b0);
    send(FUNC_DICT, 1, 1'b1);
    send(FUNC_TEXT, 25, 1'b0);
    send(FUNC_DICT, 2, 1'b0);
    send(FUNC_TEXT, 0, 1'b1);
    send(FUNC_DICT, 3, 1'b1);
    // every position reachable
    send_run(0, 40);

    // random: mostly words and texts over a few letters, some noise
    while (sent < 140) begin
      calm = (sent >= 80);
      case ($urandom_range(9))
        0, 1, 2:       send_word($urandom_range(4, 1), 3);
        3, 4, 5, 6, 7: send_text($urandom_range(12, 1), 3);
        default: send(1'($urandom_range(1)), LETTER_W'($urandom_range(31)),
                      1'($urandom_range(1)));
      endcase
    end

    // fill the trie with long random words until the node store overflows
    while (!sb.trie_full) begin
      calm = (sent < 420);
      send_word(16, 25);
    end
    calm = 1'b0;
    repeat (10) begin
      if ($urandom_range(2) == 0) send_word($urandom_range(4, 1), 25);
      send_text($urandom_range(12, 1), 3);
    end
    send_text(6, 3);

    req_if.valid <= 1'b0;
    while (sb.answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
